[rtl/core/lsbb_pkg.sv]
// lsbb_pkg: shared types, constants and codes of the lsb-first bit stream buffer
`timescale 1ns / 1ps
package lsbb_pkg;

    // store geometry
    localparam int STORE_BYTES = 512;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int LEN_W       = $clog2(STORE_BYTES * 8) + 1;
    localparam int DATA_W      = 8;
    localparam int CNT_W       = 4;
    localparam logic [LEN_W:0] CAP_BITS = (LEN_W + 1)'(STORE_BYTES * 8);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(DATA_W);

    // operation codes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_PAST  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic exec;
        logic write_hi;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hi_needed;
    } stat_t;

endpackage

[rtl/core/lsbb_item_if.sv]
// lsbb_item_if: input channel carrying one operation beat
`timescale 1ns / 1ps
interface lsbb_item_if;
    logic                            valid;
    logic                            ready;
    lsbb_pkg::op_t                   op;
    logic [lsbb_pkg::DATA_W-1:0]     data;
    logic [lsbb_pkg::CNT_W-1:0]      count;

    modport source (output valid, output op, output data, output count, input ready);
    modport sink   (input valid, input op, input data, input count, output ready);
endinterface

[rtl/core/lsbb_result_if.sv]
// lsbb_result_if: output channel carrying one result beat
`timescale 1ns / 1ps
interface lsbb_result_if;
    logic                            valid;
    logic                            ready;
    logic [lsbb_pkg::DATA_W-1:0]     read_data;
    logic [lsbb_pkg::LEN_W-1:0]      write_length;
    logic [lsbb_pkg::LEN_W-1:0]      read_position;
    lsbb_pkg::status_t               status;

    modport source (output valid, output read_data, output write_length,
                    output read_position, output status, input ready);
    modport sink   (input valid, input read_data, input write_length,
                    input read_position, input status, output ready);
endinterface

[rtl/core/lsbb_ctrl.sv]
// lsbb_ctrl: state machine sequencing accept, fetch, execute and second write
`timescale 1ns / 1ps
module lsbb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    output logic            result_valid,
    input  logic            result_ready,
    output lsbb_pkg::cmd_t  cmd,
    input  lsbb_pkg::stat_t stat
);
    import lsbb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_EXEC  = 4'b0100,
        S_HI    = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // result slot is free when empty or being drained this cycle
    assign slot_free    = !out_valid_reg || result_ready;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.fetch    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.write_hi = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (slot_free)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.hi_needed ? S_HI : S_IDLE;
            end
            S_HI:
            begin
                cmd.write_hi = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/lsbb_datapath.sv]
// lsbb_datapath: byte store, bit positions and the append/remove/read logic
`timescale 1ns / 1ps
module lsbb_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsbb_pkg::cmd_t                cmd,
    output lsbb_pkg::stat_t               stat,
    input  lsbb_pkg::op_t                 op,
    input  logic [lsbb_pkg::DATA_W-1:0]   data,
    input  logic [lsbb_pkg::CNT_W-1:0]    count,
    output logic [lsbb_pkg::DATA_W-1:0]   read_data,
    output logic [lsbb_pkg::LEN_W-1:0]    write_length,
    output logic [lsbb_pkg::LEN_W-1:0]    read_position,
    output lsbb_pkg::status_t             status
);
    import lsbb_pkg::*;

    logic [DATA_W-1:0] mem [STORE_BYTES];

    // latched beat
    op_t               op_reg;
    logic [DATA_W-1:0] data_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // positions
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  rptr_reg, rptr_next;

    // fetched bytes and pending upper byte
    logic [DATA_W-1:0] rd0_reg, rd1_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [ADDR_W-1:0] hi_addr_reg;

    // result registers
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    status_t           status_reg, status_next;

    logic [LEN_W-1:0]    len_m1;
    logic [ADDR_W-1:0]   addr0, addr1;
    logic [CNT_W-1:0]    cnt_c;
    logic [DATA_W-1:0]   cnt_mask, keep_mask, d_masked;
    logic [2*DATA_W-1:0] wide, rwin;
    logic [LEN_W:0]      app_sum, rd_sum;
    logic [CNT_W-1:0]    span;
    logic                wr_en;
    logic [DATA_W-1:0]   wr_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;

    // count clamp and masks
    assign cnt_c     = (cnt_reg > MAX_CNT) ? MAX_CNT : cnt_reg;
    assign cnt_mask  = DATA_W'((9'h1 << cnt_c) - 9'h1);
    assign keep_mask = DATA_W'((9'h1 << len_reg[2:0]) - 9'h1);
    assign d_masked  = data_reg & cnt_mask;
    assign wide      = {{DATA_W{1'b0}}, d_masked} << len_reg[2:0];
    assign rwin      = {rd1_reg, rd0_reg} >> rptr_reg[2:0];
    assign len_m1    = len_reg - LEN_W'(1);
    assign app_sum   = {1'b0, len_reg} + (LEN_W + 1)'(cnt_c);
    assign rd_sum    = {1'b0, rptr_reg} + (LEN_W + 1)'(cnt_c);
    assign span      = {1'b0, len_reg[2:0]} + cnt_c;

    // byte addresses touched by the operation
    always_comb
    begin
        case (op_reg)
            OP_APPEND: addr0 = len_reg[ADDR_W+2:3];
            OP_REMOVE: addr0 = len_m1[ADDR_W+2:3];
            default:   addr0 = rptr_reg[ADDR_W+2:3];
        endcase
    end
    assign addr1 = rptr_reg[ADDR_W+2:3] + ADDR_W'(1);

    // operation execute
    always_comb
    begin
        len_next       = len_reg;
        rptr_next      = rptr_reg;
        rdata_next     = '0;
        status_next    = ST_OK;
        wr_en          = 1'b0;
        wr_data        = rd0_reg;
        stat.hi_needed = 1'b0;
        case (op_reg)
            OP_APPEND:
            begin
                if (cnt_c != '0)
                begin
                    if (app_sum > CAP_BITS)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_data        = (rd0_reg & keep_mask) | wide[DATA_W-1:0];
                        stat.hi_needed = (span > MAX_CNT);
                        len_next       = app_sum[LEN_W-1:0];
                    end
                end
            end
            OP_REMOVE:
            begin
                if (len_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd0_reg & ~(DATA_W'(1) << len_m1[2:0]);
                    len_next = len_m1;
                end
            end
            OP_READ:
            begin
                if (cnt_c != '0)
                begin
                    if (rd_sum > {1'b0, len_reg})
                    begin
                        status_next = ST_PAST;
                    end
                    else
                    begin
                        rdata_next = rwin[DATA_W-1:0] & cnt_mask;
                        rptr_next  = rd_sum[LEN_W-1:0];
                    end
                end
            end
            OP_CLEAR:
            begin
                len_next  = '0;
                rptr_next = '0;
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    // memory write port: low byte on execute, upper byte in the following cycle
    assign mem_we    = (cmd.exec && wr_en) || cmd.write_hi;
    assign mem_waddr = cmd.write_hi ? hi_addr_reg : addr0;
    assign mem_wdata = cmd.write_hi ? hi_reg : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.fetch)
        begin
            rd0_reg <= mem[addr0];
            rd1_reg <= mem[addr1];
        end
    end

    // beat capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            data_reg <= data;
            cnt_reg  <= count;
        end
        if (cmd.exec)
        begin
            rdata_reg   <= rdata_next;
            status_reg  <= status_next;
            hi_reg      <= wide[2*DATA_W-1:DATA_W];
            hi_addr_reg <= addr0 + ADDR_W'(1);
        end
    end

    // bit positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            rptr_reg <= '0;
        end
        else if (cmd.exec)
        begin
            len_reg  <= len_next;
            rptr_reg <= rptr_next;
        end
    end

    assign read_data     = rdata_reg;
    assign write_length  = len_reg;
    assign read_position = rptr_reg;
    assign status        = status_reg;

endmodule

[rtl/core/lsb_first_bit_stream_buffer.sv]
// lsb_first_bit_stream_buffer: top level joining controller and datapath
//
// Bit buffer of 4096 bits held least significant bit first in a 512-byte
// store. Each beat on item appends 1 to 8 bits, removes the last bit, reads
// 1 to 8 bits or clears both positions, and yields one beat on result with
// the read bits, the new write length and read position, and a status code.
// An item passes through accept, fetch of both bytes and execute; an append
// that spans two bytes adds an upper byte write in a cycle of its own, since
// the store has one write port. The result waits in an output register, and
// a new item is accepted while it waits; execution of that item holds until
// the result has been taken. No clearing pass after reset.
`timescale 1ns / 1ps
module lsb_first_bit_stream_buffer (
    input  logic    clk,
    input  logic    rst_n,
    lsbb_item_if.sink     item,
    lsbb_result_if.source result
);
    import lsbb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing
    lsbb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    // store and arithmetic
    lsbb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op            (item.op),
        .data          (item.data),
        .count         (item.count),
        .read_data     (result.read_data),
        .write_length  (result.write_length),
        .read_position (result.read_position),
        .status        (result.status)
    );

endmodule

[dv/tb_lsb_first_bit_stream_buffer.sv]
// tb_lsb_first_bit_stream_buffer: self-checking testbench of the lsb-first bit stream buffer
`timescale 1ns / 1ps
module tb_lsb_first_bit_stream_buffer;
    import lsbb_pkg::*;

    localparam int TAIL_ITEMS   = 150;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int CAP          = STORE_BYTES * 8;

    // one pending operation, or a marker that holds the sender until drained
    typedef struct {
        op_t              op;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        bit               hold;
    } stim_item_t;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic [LEN_W-1:0]  write_length;
        logic [LEN_W-1:0]  read_position;
        status_t           status;
    } result_beat_t;

    logic clk;
    logic rst_n;

    lsbb_item_if   item_ch ();
    lsbb_result_if result_ch ();

    lsb_first_bit_stream_buffer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    stim_item_t   stim_items[$];
    result_beat_t expected_beats[$];
    stim_item_t   head_item;

    // shadow copy of the buffer contents and positions
    bit [7:0] shadow_bytes [STORE_BYTES];
    int       shadow_len;
    int       shadow_rptr;

    int items_sent;
    int results_seen;
    int errors;
    int idle_cycles;
    int gap;
    int stall;
    bit calm;

    // apply one operation to the shadow buffer and return the result it yields
    function automatic result_beat_t buffer_apply(op_t op, logic [DATA_W-1:0] data,
                                                  logic [CNT_W-1:0] count);
        result_beat_t r;
        int n;
        int pos;
        int sh;
        int bits;
        int v;
        r.read_data = '0;
        r.status    = ST_OK;
        n = (count > MAX_CNT) ? DATA_W : int'(count);
        pos = 0;
        sh  = 0;
        case (op)
            OP_APPEND:
            begin
                if (n > 0)
                begin
                    if (shadow_len + n > CAP)
                        r.status = ST_FULL;
                    else
                    begin
                        pos  = shadow_len >> 3;
                        sh   = shadow_len & 7;
                        bits = int'(data) & ((1 << n) - 1);
                        shadow_bytes[pos] = (shadow_bytes[pos] & 8'((1 << sh) - 1))
                                            | 8'(bits << sh);
                        // append spills into the next byte
                        if (sh + n > 8)
                            shadow_bytes[pos + 1] = 8'(bits >> (8 - sh));
                        shadow_len += n;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    shadow_len -= 1;
                    shadow_bytes[shadow_len >> 3][shadow_len & 7] = 1'b0;
                end
            end
            OP_READ:
            begin
                if (n > 0)
                begin
                    if (shadow_rptr + n > shadow_len)
                        r.status = ST_PAST;
                    else
                    begin
                        pos = shadow_rptr >> 3;
                        sh  = shadow_rptr & 7;
                        v   = int'(shadow_bytes[pos]) >> sh;
                        if (sh + n > 8)
                            v |= int'(shadow_bytes[pos + 1]) << (8 - sh);
                        r.read_data = 8'(v & ((1 << n) - 1));
                        shadow_rptr += n;
                    end
                end
            end
            default:
            begin
                shadow_len  = 0;
                shadow_rptr = 0;
            end
        endcase
        r.write_length  = LEN_W'(shadow_len);
        r.read_position = LEN_W'(shadow_rptr);
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic queue_item(op_t op, int data, int count, bit hold = 1'b0);
        stim_item_t s;
        s.op    = op;
        s.data  = DATA_W'(data);
        s.count = CNT_W'(count);
        s.hold  = hold;
        stim_items.insert(stim_items.size(), s);
    endtask

    // mostly appends and reads with random content, some removes, clears and odd counts
    task automatic queue_mixed(int n);
        int r;
        int cnt;
        op_t op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = OP_APPEND;
            else if (r < 75)
                op = OP_READ;
            else if (r < 92)
                op = OP_REMOVE;
            else if (r < 95)
                op = OP_CLEAR;
            else
                op = op_t'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
                cnt = $urandom_range(0, 15);
            else
                cnt = $urandom_range(1, 8);
            queue_item(op, $urandom_range(0, 255), cnt);
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver: presents pending items, idles in bursts, honors drain markers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            gap           <= 0;
            calm          <= 1'b0;
            items_sent    <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_beats.insert(expected_beats.size(),
                                      buffer_apply(item_ch.op, item_ch.data, item_ch.count));
                items_sent <= items_sent + 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap != 0)
                begin
                    item_ch.valid <= 1'b0;
                    gap           <= gap - 1;
                end
                else if (stim_items.size() == 0)
                    item_ch.valid <= 1'b0;
                else if (stim_items[0].hold)
                begin
                    // pause until every issued beat has come back
                    item_ch.valid <= 1'b0;
                    if (items_sent + int'(item_ch.valid) == results_seen)
                        void'(stim_items.pop_front());
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    item_ch.valid <= 1'b0;
                    gap           <= $urandom_range(0, 11);
                end
                else
                begin
                    head_item      = stim_items.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.op    <= head_item.op;
                    item_ch.data  <= head_item.data;
                    item_ch.count <= head_item.count;
                end
                calm <= (stim_items.size() < TAIL_ITEMS);
            end
        end
    end

    // monitor: checks each result beat against the oldest expectation, stalls in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall           <= 0;
            results_seen    <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none actual status %0d",
                             $time, result_ch.status);
                end
                else
                begin
                    result_beat_t want;
                    want = expected_beats.pop_front();
                    check_field("read_data", 16'(want.read_data), 16'(result_ch.read_data));
                    check_field("write_length", 16'(want.write_length),
                                16'(result_ch.write_length));
                    check_field("read_position", 16'(want.read_position),
                                16'(result_ch.read_position));
                    check_field("status", 16'(want.status), 16'(result_ch.status));
                end
            end
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                stall           <= stall - 1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall           <= $urandom_range(0, 11);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog: cycles in which no beat moves on either channel
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus, reset and end of run
    initial
    begin
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.op    = OP_APPEND;
        item_ch.data  = '0;
        item_ch.count = '0;
        result_ch.ready = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        shadow_len  = 0;
        shadow_rptr = 0;

        // directed: empty buffer cases
        queue_item(OP_READ, 0, 1);
        queue_item(OP_REMOVE, 0, 1);
        // field extremes, zero count and counts above eight
        queue_item(OP_APPEND, 8'hFF, 8);
        queue_item(OP_APPEND, 8'h00, 8);
        queue_item(OP_APPEND, 8'hA5, 0);
        queue_item(OP_APPEND, 8'h5A, 15);
        queue_item(OP_APPEND, 8'h7F, 7);
        queue_item(OP_APPEND, 8'h1F, 5);
        queue_item(OP_READ, 0, 8);
        queue_item(OP_READ, 0, 0);
        queue_item(OP_READ, 0, 9);
        queue_item(OP_READ, 0, 3);
        queue_item(OP_READ, 0, 7);
        // append after removal must not bring back stale bits
        queue_item(OP_REMOVE, 0, 1);
        queue_item(OP_REMOVE, 0, 1);
        queue_item(OP_APPEND, 8'hFF, 2);
        queue_item(OP_READ, 0, 8);
        // removal below the read position
        queue_item(OP_CLEAR, 8'hFF, 15);
        queue_item(OP_APPEND, 8'hC3, 4);
        queue_item(OP_READ, 0, 4);
        queue_item(OP_REMOVE, 0, 1);
        queue_item(OP_REMOVE, 0, 1);
        queue_item(OP_READ, 0, 1);
        queue_item(OP_APPEND, 8'h0F, 4);
        queue_item(OP_READ, 0, 2);
        queue_item(OP_CLEAR, 0, 0, 1'b1);

        queue_mixed(300);

        // fill the store completely, with reads along the way
        queue_item(OP_CLEAR, 0, 1);
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            queue_item(OP_APPEND, $urandom_range(0, 255), 8);
            if ($urandom_range(0, 7) == 0)
                queue_item(OP_READ, 0, $urandom_range(1, 8));
        end
        // overflow at and near the full store
        queue_item(OP_APPEND, $urandom_range(0, 255), 1);
        queue_item(OP_APPEND, $urandom_range(0, 255), 8);
        queue_item(OP_REMOVE, 0, 1);
        queue_item(OP_REMOVE, 0, 1);
        queue_item(OP_REMOVE, 0, 1);
        queue_item(OP_APPEND, $urandom_range(0, 255), 4);
        queue_item(OP_APPEND, $urandom_range(0, 255), 3);
        queue_item(OP_APPEND, $urandom_range(0, 255), 1);
        queue_item(OP_READ, 0, 8);
        queue_item(OP_READ, 0, 5);
        queue_item(OP_CLEAR, 0, 0, 1'b1);
        queue_item(OP_CLEAR, 0, 0);

        queue_mixed(150);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while ((stim_items.size() != 0 || expected_beats.size() != 0 || item_ch.valid)
               && idle_cycles < STALL_LIMIT)
            @(posedge clk);

        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d beats outstanding",
                     $time, expected_beats.size());
            $display("** lsb_first_bit_stream_buffer: FAILED **");
            $finish;
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (expected_beats.size() != 0)
            begin
                errors++;
                $display("%0t: result beats missing, expected %0d actual 0",
                         $time, expected_beats.size());
            end
            if (errors == 0)
                $display("** lsb_first_bit_stream_buffer: PASSED **");
            else
                $display("** lsb_first_bit_stream_buffer: FAILED **");
            $finish;
        end
    end

endmodule
